>>> hw/rtl/sliding_hamming_distance_sum_defines.svh
// Assertion macros for the sliding Hamming distance sum block
`ifndef SLIDING_HAMMING_DISTANCE_SUM_DEFINES_SVH
`define SLIDING_HAMMING_DISTANCE_SUM_DEFINES_SVH

`ifndef ASSERT_OFF

`define SHDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define SHDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SHDS_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define SHDS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/shds_pkg.sv
// Shared types and constants for the sliding Hamming distance sum block
package shds_pkg;

   localparam int DEF_MAX_PATTERN = 64;
   localparam int DEF_MAX_LONG    = 4096;
   localparam int DEF_SYMBOL_BITS = 4;

   localparam int SYMBOL_W = 4;
   localparam int TOTAL_W  = 19;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic MODE_PATTERN = 1'b0;
   localparam logic MODE_LONG    = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_distance;
      logic               too_short;
   } rsp_type;

   // step: a long-read symbol is scored and counts move up the row; load: a pattern symbol shifts in
   typedef struct packed {
      logic step;
      logic load;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/shds_cell.sv
// One cell of the row: a pattern symbol and a partial mismatch count
module shds_cell
   import shds_pkg::*;
#(
   parameter int SYM_W = DEF_SYMBOL_BITS,
   parameter int CNT_W = 7
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic              on,
   input  logic [SYM_W-1:0]  sym,
   input  logic [SYM_W-1:0]  pat_in,
   output logic [SYM_W-1:0]  pat_out,
   input  logic [CNT_W-1:0]  acc_in,
   output logic [CNT_W-1:0]  acc_out
);

   logic [SYM_W-1:0] pat_ff;
   logic [CNT_W-1:0] acc_ff;
   logic [CNT_W-1:0] acc_in_sum;
   logic             miss;

   assign miss       = on && (pat_ff != sym);
   assign acc_in_sum = acc_in + CNT_W'(miss);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pat_ff <= pat_in;
      end
      if (ctrl.step) begin
         acc_ff <= acc_in_sum;
      end
   end

   assign pat_out = pat_ff;
   assign acc_out = acc_ff;

endmodule

>>> hw/rtl/shds_chain.sv
// Row of cells: pattern held right-aligned, partial counts flow upwards
module shds_chain
   import shds_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN,
   parameter int SYM_W       = DEF_SYMBOL_BITS,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
   parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [LEN_W-1:0]  pat_len,
   input  logic [SYM_W-1:0]  sym,
   output logic [CNT_W-1:0]  score
);

   logic [SYM_W-1:0] pat_q [MAX_PATTERN];
   logic [CNT_W-1:0] acc_q [MAX_PATTERN];
   logic             on    [MAX_PATTERN];

   genvar j;
   generate
      for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
         logic [SYM_W-1:0] pat_src;
         logic [CNT_W-1:0] acc_src;

         // cell j holds pattern element j - (MAX_PATTERN - len) when active
         assign on[j] = pat_len >= LEN_W'(MAX_PATTERN - j);

         if (j == MAX_PATTERN - 1) begin : g_top
            assign pat_src = sym;
         end else begin : g_mid
            assign pat_src = pat_q[j+1];
         end

         // a window starts fresh in the lowest active cell
         if (j == 0) begin : g_first
            assign acc_src = '0;
         end else begin : g_rest
            assign acc_src = on[j-1] ? acc_q[j-1] : '0;
         end

         shds_cell #(
            .SYM_W (SYM_W),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock   (clock),
            .ctrl    (ctrl),
            .on      (on[j]),
            .sym     (sym),
            .pat_in  (pat_src),
            .pat_out (pat_q[j]),
            .acc_in  (acc_src),
            .acc_out (acc_q[j])
         );
      end
   endgenerate

   assign score = on[MAX_PATTERN-1] ? acc_q[MAX_PATTERN-1] : '0;

endmodule

>>> hw/rtl/sliding_hamming_distance_sum.sv
// Top level: sliding-window Hamming distance sum over a row of cells
//
//  port group   dir  handshake           payload
//  req_data     in   start & !busy       req_type  (mode, symbol, last)
//  rsp_data     out  rsp_strobe, 1 cycle rsp_type  (total_distance, too_short)
//
// One item per clock; busy stays low. Each long-read symbol is broadcast to
// every cell at once and each cell adds its mismatch to the count from the
// cell below, so a window score leaves the top cell in the cycle after the
// symbol. The running total is updated in the cycle after that; the last
// long-read item sets last_ff, which registers the result. Synchronous reset
// clears lengths, counts and the total; the receiver cannot stall the result.
module sliding_hamming_distance_sum
   import shds_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN,
   parameter int MAX_LONG    = DEF_MAX_LONG,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

`include "sliding_hamming_distance_sum_defines.svh"

   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int LONG_W = $clog2(MAX_LONG + 1);
   localparam int CMP_W  = (LONG_W > LEN_W) ? LONG_W : LEN_W;

   logic [SYMBOL_BITS-1:0] sym;
   logic                   accept;
   logic                   is_pat;
   logic                   is_long;
   logic                   new_pat;
   logic [LEN_W-1:0]       len_base;
   logic [LEN_W-1:0]       pat_len_in;
   logic [LONG_W-1:0]      long_count_in;
   logic                   cnt_ge;
   logic [CNT_W-1:0]       score;
   logic [TOTAL_W:0]       sum_wide;
   logic [TOTAL_W-1:0]     total_in;
   cell_ctrl_type          ctrl;

   logic [LEN_W-1:0]       pat_len_ff;
   logic                   pat_done_ff;
   logic [LONG_W-1:0]      long_count_ff;
   logic [TOTAL_W-1:0]     total_ff;
   logic                   score_valid_ff;
   logic                   last_ff;
   logic                   short_ff;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_ff;

   generate
      if (SYMBOL_BITS <= SYMBOL_W) begin : g_sym_narrow
         assign sym = req_data.symbol[SYMBOL_BITS-1:0];
      end else begin : g_sym_wide
         assign sym = {{(SYMBOL_BITS - SYMBOL_W){1'b0}}, req_data.symbol};
      end
   endgenerate

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign is_pat  = accept && (req_data.mode == MODE_PATTERN);
   assign is_long = accept && (req_data.mode == MODE_LONG);
   assign new_pat = is_pat && pat_done_ff;

   // pattern elements beyond the row are dropped, the last mark still counts
   assign len_base   = new_pat ? '0 : pat_len_ff;
   assign ctrl.load  = is_pat && (len_base < LEN_W'(MAX_PATTERN));
   assign pat_len_in = ctrl.load ? len_base + LEN_W'(1) : len_base;

   assign ctrl.step     = is_long && (long_count_ff < LONG_W'(MAX_LONG));
   assign long_count_in = ctrl.step ? long_count_ff + LONG_W'(1) : long_count_ff;
   assign cnt_ge        = CMP_W'(long_count_in) >= CMP_W'(pat_len_ff);

   shds_chain #(
      .MAX_PATTERN (MAX_PATTERN),
      .SYM_W       (SYMBOL_BITS),
      .LEN_W       (LEN_W),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock   (clock),
      .ctrl    (ctrl),
      .pat_len (pat_len_ff),
      .sym     (sym),
      .score   (score)
   );

   // score is the top cell's count for the transaction held in the score stage
   assign sum_wide = {1'b0, total_ff}
                   + (score_valid_ff ? (TOTAL_W+1)'(score) : '0);
   assign total_in = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff     <= '0;
         pat_done_ff    <= 1'b0;
         long_count_ff  <= '0;
         total_ff       <= '0;
         score_valid_ff <= 1'b0;
         last_ff        <= 1'b0;
         short_ff       <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         pat_len_ff     <= pat_len_in;
         score_valid_ff <= ctrl.step && cnt_ge;
         last_ff        <= is_long && req_data.last;
         short_ff       <= !cnt_ge;
         rsp_strobe_ff  <= last_ff;

         if (is_long) begin
            pat_done_ff <= 1'b1;
         end else if (is_pat) begin
            pat_done_ff <= req_data.last;
         end

         if (new_pat || (is_long && req_data.last)) begin
            long_count_ff <= '0;
         end else begin
            long_count_ff <= long_count_in;
         end

         if (new_pat || last_ff) begin
            total_ff <= '0;
         end else begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (last_ff) begin
         rsp_ff.total_distance <= short_ff ? '0 : total_in;
         rsp_ff.too_short      <= short_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `SHDS_ASSERT_IMP(a_short_zero, clock, reset, rsp_strobe && rsp_data.too_short, rsp_data.total_distance == '0)
   `SHDS_ASSERT_NXT(a_last_emits, clock, reset, last_ff, rsp_strobe)
   `SHDS_ASSERT_NXT(a_no_spurious, clock, reset, !last_ff, !rsp_strobe)
   `SHDS_ASSERT_NXT(a_new_pat_clear, clock, reset, new_pat, long_count_ff == '0 && pat_len_ff == LEN_W'(1))

endmodule

>>> verif/sliding_hamming_distance_sum_tb.sv
// Testbench for the sliding Hamming distance sum block: directed and random streams
`timescale 1ns / 100ps

module sliding_hamming_distance_sum_tb;
   import shds_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int TAIL_CYCLES  = 8;
   localparam logic [SYMBOL_W-1:0] SYM_MASK = SYMBOL_W'((1 << DEF_SYMBOL_BITS) - 1);

   typedef struct {
      req_type     payload;
      int unsigned gap;
      bit          drain;
   } stim_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   sliding_hamming_distance_sum dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // predictor state
   logic [SYMBOL_W-1:0] pat_sym     [DEF_MAX_PATTERN] = '{default: '0};
   logic [SYMBOL_W-1:0] recent_long [DEF_MAX_PATTERN] = '{default: '0};
   int unsigned pat_len      = 0;
   bit          pat_closed   = 1'b0;
   int unsigned long_seen    = 0;
   int unsigned mismatch_sum = 0;
   rsp_type     expected_totals [$];

   stim_entry_type send_queue [$];

   int unsigned cycle_count     = 0;
   int unsigned fail_count      = 0;
   int unsigned items_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned short_results   = 0;
   int unsigned peak_total      = 0;
   rsp_type     want_rsp;

   // stimulus shaping
   int unsigned stim_items = 0;
   bit          burst      = 1'b0;
   bit          drain_next = 1'b0;
   bit          echo       = 1'b0;
   int unsigned alph_hi    = 15;
   logic [SYMBOL_W-1:0] tb_pat [DEF_MAX_PATTERN] = '{default: '0};
   int unsigned tb_plen    = 0;

   function automatic void clear_long_state();
      recent_long  = '{default: '0};
      long_seen    = 0;
      mismatch_sum = 0;
   endfunction

   function automatic void score_element(req_type item);
      logic [SYMBOL_W-1:0] sym;
      int unsigned mism;
      int i;
      rsp_type res;
      sym = item.symbol & SYM_MASK;
      if (item.mode == MODE_PATTERN) begin
         if (pat_closed) begin
            pat_len    = 0;
            pat_closed = 1'b0;
            clear_long_state();
         end
         if (pat_len < DEF_MAX_PATTERN) begin
            pat_sym[pat_len] = sym;
            pat_len++;
         end
         if (item.last) pat_closed = 1'b1;
         return;
      end
      pat_closed = 1'b1;
      if (long_seen < DEF_MAX_LONG) begin
         for (i = DEF_MAX_PATTERN - 1; i > 0; i--) recent_long[i] = recent_long[i-1];
         recent_long[0] = sym;
         long_seen++;
         if (long_seen >= pat_len) begin
            mism = 0;
            // newest element lines up with the final pattern position
            for (i = 0; i < pat_len; i++)
               if (pat_sym[i] != recent_long[pat_len-1-i]) mism++;
            mismatch_sum += mism;
            if (mismatch_sum > TOTAL_MAX) mismatch_sum = TOTAL_MAX;
         end
      end
      if (!item.last) return;
      if (long_seen < pat_len) begin
         res.total_distance = '0;
         res.too_short      = 1'b1;
      end else begin
         res.total_distance = mismatch_sum[TOTAL_W-1:0];
         res.too_short      = 1'b0;
      end
      expected_totals.insert(expected_totals.size(), res);
      clear_long_state();
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            score_element(req_data);
            items_accepted++;
         end
         if (!start || !busy) begin
            if (send_queue.size() == 0) begin
               start <= 1'b0;
            end else if (send_queue[0].gap != 0) begin
               send_queue[0].gap--;
               start <= 1'b0;
            end else if (send_queue[0].drain && expected_totals.size() != 0) begin
               start <= 1'b0;
            end else begin
               start    <= 1'b1;
               req_data <= send_queue[0].payload;
               send_queue.delete(0);
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_totals.size() == 0) begin
            $display("%0t: unexpected result: expected none, got total=%0d too_short=%0b",
                     $time, rsp_data.total_distance, rsp_data.too_short);
            fail_count++;
         end else begin
            want_rsp = expected_totals.pop_front();
            if (rsp_data.total_distance !== want_rsp.total_distance) begin
               $display("%0t: total_distance mismatch: expected %0d, got %0d",
                        $time, want_rsp.total_distance, rsp_data.total_distance);
               fail_count++;
            end
            if (rsp_data.too_short !== want_rsp.too_short) begin
               $display("%0t: too_short mismatch: expected %0b, got %0b",
                        $time, want_rsp.too_short, rsp_data.too_short);
               fail_count++;
            end
            results_checked++;
            if (want_rsp.too_short) short_results++;
            if (want_rsp.total_distance > peak_total) peak_total = want_rsp.total_distance;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out after %0d cycles", $time, cycle_count);
         $display("sliding_hamming_distance_sum_tb NOT OK");
         $finish;
      end
   end

   task automatic add_item(logic mode, logic [SYMBOL_W-1:0] sym, logic last_flag);
      stim_entry_type e;
      e.payload.mode   = mode;
      e.payload.symbol = sym;
      e.payload.last   = last_flag;
      e.gap            = burst ? 0 : $urandom_range(0, 9);
      e.drain          = drain_next;
      drain_next       = 1'b0;
      send_queue.insert(send_queue.size(), e);
      stim_items++;
   endtask

   function automatic logic [SYMBOL_W-1:0] rand_sym();
      return SYMBOL_W'($urandom_range(0, alph_hi));
   endfunction

   task automatic add_pattern(int unsigned n, bit mark_last);
      logic [SYMBOL_W-1:0] sym;
      int unsigned k;
      for (k = 0; k < n; k++) begin
         sym = rand_sym();
         if (k < DEF_MAX_PATTERN) tb_pat[k] = sym;
         add_item(MODE_PATTERN, sym, mark_last && (k == n - 1));
      end
      tb_plen = (n > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : n;
   endtask

   task automatic add_long(int unsigned n, bit mark_last);
      logic [SYMBOL_W-1:0] sym;
      int unsigned k;
      for (k = 0; k < n; k++) begin
         // echoing the pattern keeps some windows close to a match
         if (echo && tb_plen != 0 && $urandom_range(0, 3) != 0)
            sym = tb_pat[k % tb_plen];
         else
            sym = rand_sym();
         add_item(MODE_LONG, sym, mark_last && (k == n - 1));
      end
   endtask

   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 88) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, DEF_MAX_PATTERN - 1);
      return DEF_MAX_PATTERN;
   endfunction

   initial begin
      int unsigned sel;
      int unsigned plen;
      int unsigned k;
      bit long_pat_done;

      // empty pattern straight after reset
      add_item(MODE_LONG, 4'hF, 1'b0);
      add_item(MODE_LONG, 4'h0, 1'b1);
      // three-element pattern, then a short and a full long read
      add_item(MODE_PATTERN, 4'hF, 1'b0);
      add_item(MODE_PATTERN, 4'h0, 1'b0);
      add_item(MODE_PATTERN, 4'h9, 1'b1);
      add_item(MODE_LONG, 4'hF, 1'b0);
      add_item(MODE_LONG, 4'h0, 1'b1);
      add_item(MODE_LONG, 4'hF, 1'b0);
      add_item(MODE_LONG, 4'h0, 1'b0);
      add_item(MODE_LONG, 4'h9, 1'b0);
      add_item(MODE_LONG, 4'h9, 1'b0);
      add_item(MODE_LONG, 4'hF, 1'b1);
      // new pattern after a finished one, closed by a long element
      add_item(MODE_PATTERN, 4'h0, 1'b0);
      add_item(MODE_PATTERN, 4'hF, 1'b0);
      add_item(MODE_LONG, 4'h0, 1'b0);
      add_item(MODE_LONG, 4'hF, 1'b1);
      // single-element pattern
      add_item(MODE_PATTERN, 4'h5, 1'b1);
      add_item(MODE_LONG, 4'h5, 1'b1);
      add_item(MODE_LONG, 4'hA, 1'b1);
      // unfinished long read abandoned by a new pattern
      add_item(MODE_LONG, 4'h3, 1'b0);
      add_item(MODE_PATTERN, 4'h7, 1'b1);
      add_item(MODE_LONG, 4'h7, 1'b1);

      drain_next     = 1'b1;
      long_pat_done  = 1'b0;
      plen           = 1;
      k              = stim_items;
      while (stim_items < k + RANDOM_ITEMS) begin
         burst   = ($urandom_range(0, 5) == 0);
         echo    = 1'($urandom_range(0, 1));
         sel     = $urandom_range(0, 2);
         alph_hi = (sel == 0) ? 1 : (sel == 1) ? 3 : 15;
         if ($urandom_range(0, 24) == 0) drain_next = 1'b1;

         if (!long_pat_done && stim_items > k + 300) begin
            // pattern beyond the store, last mark on a dropped element
            long_pat_done = 1'b1;
            add_pattern(DEF_MAX_PATTERN + 6, 1'b1);
            add_long($urandom_range(DEF_MAX_PATTERN - 2, DEF_MAX_PATTERN + 20), 1'b1);
            plen = DEF_MAX_PATTERN;
            continue;
         end

         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            plen = pick_len();
            add_pattern(plen, 1'b1);
            add_long($urandom_range(1, plen + 10), 1'b1);
         end else if (sel < 70) begin
            add_long($urandom_range(1, plen + 10), 1'b1);
         end else if (sel < 80) begin
            plen = pick_len();
            add_pattern(plen, 1'b0);
            add_long($urandom_range(1, plen + 10), 1'b1);
         end else if (sel < 90) begin
            repeat ($urandom_range(1, 12))
               add_item(1'($urandom_range(0, 1)), SYMBOL_W'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)));
         end else begin
            plen = pick_len();
            add_pattern(plen, 1'($urandom_range(0, 1)));
            add_long($urandom_range(1, plen + 4), 1'b0);
         end
      end
      // flush whatever long read the noise left open
      add_item(MODE_LONG, 4'h0, 1'b1);

      @(posedge clock);
      while (reset || send_queue.size() != 0 || start) @(posedge clock);
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d transactions; checked %0d totals, %0d of them short long reads.",
               items_accepted, results_checked, short_results);
      $display("Largest total seen %0d, run took %0d cycles.", peak_total, cycle_count);
      if (fail_count == 0)
         $display("sliding_hamming_distance_sum_tb OK");
      else
         $display("sliding_hamming_distance_sum_tb NOT OK");
      $finish;
   end

endmodule

>>> sliding_hamming_distance_sum.f
+incdir+hw/rtl
hw/rtl/shds_pkg.sv
hw/rtl/shds_cell.sv
hw/rtl/shds_chain.sv
hw/rtl/sliding_hamming_distance_sum.sv
verif/sliding_hamming_distance_sum_tb.sv
